// ===== sv/mbe_pkg.sv =====
// ============================================================================
// mbe_pkg: shared types and constants for the Mandelbrot escape-time block
// Holds field widths, the APB register map, the control word layout and the
// microcode program that sequences one escape-time iteration.
// ============================================================================
`timescale 1ns / 1ps

package mbe_pkg;

    // Payload widths.
    localparam int Z_W    = 64;
    localparam int HALF_W = 32;
    localparam int ACC_W  = 128;
    localparam int IC_W   = 16;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int MAXIT_W = 16;
    localparam logic [APB_AW-3:0] CFG_MAX_ITER = '0;
    localparam logic [MAXIT_W-1:0] MAXIT_RST = 16'd255;

    // Step counter layout of the microcode program.
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_CHECK = 5'd0;
    localparam logic [PC_W-1:0] PC_RR    = 5'd1;
    localparam logic [PC_W-1:0] PC_II    = 5'd8;
    localparam logic [PC_W-1:0] PC_RI    = 5'd15;
    localparam logic [PC_W-1:0] PC_UPD   = 5'd22;

    // Which product a step works on; also the destination of the product.
    typedef enum logic [1:0] {
        OP_RR = 2'd0,
        OP_II = 2'd1,
        OP_RI = 2'd2
    } t_osel;

    // Alignment of a partial product within the accumulator.
    typedef enum logic [1:0] {
        ASH_0  = 2'd0,
        ASH_32 = 2'd1,
        ASH_64 = 2'd2
    } t_ash;

    // Sequencing of the step counter.
    typedef enum logic [1:0] {
        BR_NEXT  = 2'd0,
        BR_LIMIT = 2'd1,
        BR_LOOP  = 2'd2
    } t_br;

    // One control word.
    typedef struct packed {
        logic  ld;     // latch operand magnitudes and sign, clear accumulator
        t_osel osel;   // operand pair and destination
        logic  mul;    // register one 32x32 partial product
        logic  a_hi;   // upper half of operand A into the multiplier
        logic  b_hi;   // upper half of operand B into the multiplier
        logic  acc;    // add the registered partial product
        t_ash  ash;    // alignment of that partial product
        logic  st;     // round, sign and store the finished product
        t_br   br;     // step counter control
    } t_uop;

    // Seven steps form one signed 64x64 fixed-point product.
    function automatic t_uop prod_step(input t_osel osel, input logic [2:0] off);
        t_uop u;
        u      = '0;
        u.osel = osel;
        u.br   = BR_NEXT;
        unique case (off)
            3'd0: u.ld = 1'b1;
            3'd1: u.mul = 1'b1;
            3'd2: begin
                u.mul  = 1'b1;
                u.b_hi = 1'b1;
                u.acc  = 1'b1;
                u.ash  = ASH_0;
            end
            3'd3: begin
                u.mul  = 1'b1;
                u.a_hi = 1'b1;
                u.acc  = 1'b1;
                u.ash  = ASH_32;
            end
            3'd4: begin
                u.mul  = 1'b1;
                u.a_hi = 1'b1;
                u.b_hi = 1'b1;
                u.acc  = 1'b1;
                u.ash  = ASH_32;
            end
            3'd5: begin
                u.acc = 1'b1;
                u.ash = ASH_64;
            end
            3'd6: u.st = 1'b1;
            default: ;
        endcase
        return u;
    endfunction

    // Program: limit check, three products, then the z update and escape test.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u    = '0;
        u.br = BR_NEXT;
        priority if (pc == PC_CHECK) begin
            u.br = BR_LIMIT;
        end else if (pc < PC_II) begin
            u = prod_step(OP_RR, 3'(pc - PC_RR));
        end else if (pc < PC_RI) begin
            u = prod_step(OP_II, 3'(pc - PC_II));
        end else if (pc < PC_UPD) begin
            u = prod_step(OP_RI, 3'(pc - PC_RI));
        end else if (pc == PC_UPD) begin
            u.br = BR_LOOP;
        end else begin
            u.br = BR_NEXT;
        end
        return u;
    endfunction

endpackage

// ===== sv/mbe_in_if.sv =====
// ============================================================================
// mbe_in_if: request channel carrying one point c
// Valid/ready handshake with the real and imaginary parts of the point.
// ============================================================================
`timescale 1ns / 1ps

interface mbe_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [mbe_pkg::Z_W-1:0]   c_real;
    logic signed [mbe_pkg::Z_W-1:0]   c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// ===== sv/mbe_out_if.sv =====
// ============================================================================
// mbe_out_if: result channel carrying the escape count
// Valid/ready handshake with the iteration count and the escaped flag.
// ============================================================================
`timescale 1ns / 1ps

interface mbe_out_if;
    logic                      valid;
    logic                      ready;
    logic [mbe_pkg::IC_W-1:0]  iteration_count;
    logic                      escaped;

    modport source (output valid, output iteration_count, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

// ===== sv/mandelbrot_escape_iteration.sv =====
// ============================================================================
// mandelbrot_escape_iteration: escape-time iteration for one point c
// Each completed pass is a limit check, three products of seven steps on
//   one shared 32x32 multiplier and a z update; the final limit check or the
//   escape test ends the run, and the result goes to the output register.
// Throughput: one request at a time; a new request is taken once the
//   result has moved to the output register. Reset is synchronous and
//   active low; max_iterations returns to 255 and the sequencer goes idle.
// ============================================================================
`timescale 1ns / 1ps

module mandelbrot_escape_iteration #(
    parameter int FRAC_BITS  = 56,
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mbe_in_if.sink                        i_pt,
    mbe_out_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbe_pkg::APB_AW-1:0]    paddr,
    input  logic [mbe_pkg::APB_DW-1:0]    pwdata,
    output logic [mbe_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // The escape threshold: an integer part above four means m >= 5.0.
    localparam logic [mbe_pkg::Z_W-1:0] LimFive = 64'd5 << FRAC_BITS;
    localparam int IcW = mbe_pkg::IC_W;

    // Top-level control. The sequencer runs only in the RUN state; DONE holds
    // the finished count until the output register can take it.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [mbe_pkg::PC_W-1:0]        r_pc, n_pc;
    logic [COUNT_BITS-1:0]           r_cnt, n_cnt;
    logic [COUNT_BITS-1:0]           r_limit;
    logic                            r_res_esc, n_res_esc;
    logic                            r_o_valid, n_o_valid;
    logic [IcW-1:0]                  r_o_cnt;
    logic                            r_o_esc;
    logic [mbe_pkg::MAXIT_W-1:0]     r_max;

    // Datapath registers.
    logic [mbe_pkg::Z_W-1:0]         r_zr, r_zi, r_cr, r_ci;
    logic [mbe_pkg::Z_W-1:0]         r_rr, r_ii, r_ri;
    logic [mbe_pkg::Z_W-1:0]         r_ma, r_mb;
    logic                            r_neg;
    logic [mbe_pkg::Z_W-1:0]         r_pp;
    logic [mbe_pkg::ACC_W-1:0]       r_acc;

    mbe_pkg::t_uop                   w_uop;
    logic [mbe_pkg::Z_W-1:0]         w_opa, w_opb;
    logic [mbe_pkg::HALF_W-1:0]      w_mul_a, w_mul_b;
    logic [mbe_pkg::Z_W-1:0]         w_pp;
    logic [mbe_pkg::ACC_W-1:0]       w_acc_add;
    logic [mbe_pkg::ACC_W-1:0]       w_sgn;
    logic [mbe_pkg::Z_W-1:0]         w_prod;
    logic [mbe_pkg::Z_W-1:0]         w_zr_n, w_zi_n, w_mag;
    logic                            w_esc;
    logic                            w_at_limit;
    logic                            w_slot_free;
    logic                            w_accept;
    logic                            w_cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port. The only register is max_iterations at index 0;
    // writes to any other index are dropped and read back as zero.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                   && (paddr[mbe_pkg::APB_AW-1:2] == mbe_pkg::CFG_MAX_ITER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= mbe_pkg::MAXIT_RST;
        end else if (w_cfg_wr) begin
            r_max <= pwdata[mbe_pkg::MAXIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[mbe_pkg::APB_AW-1:2] == mbe_pkg::CFG_MAX_ITER) begin
            prdata[mbe_pkg::MAXIT_W-1:0] = r_max;
        end
    end

    // ------------------------------------------------------------------
    // Microcode fetch. The control word is decoded straight from the
    // step counter; the program lives in the package.
    // ------------------------------------------------------------------
    assign w_uop = mbe_pkg::uop_rom(r_pc);

    // Operand pair for the current product.
    always_comb begin
        unique case (w_uop.osel)
            mbe_pkg::OP_RR: begin
                w_opa = r_zr;
                w_opb = r_zr;
            end
            mbe_pkg::OP_II: begin
                w_opa = r_zi;
                w_opb = r_zi;
            end
            mbe_pkg::OP_RI: begin
                w_opa = r_zr;
                w_opb = r_zi;
            end
            default: begin
                w_opa = r_zr;
                w_opb = r_zr;
            end
        endcase
    end

    // The product is formed on magnitudes, one 32x32 partial product per
    // step, and the sign is applied to the full 128-bit result at the end.
    assign w_mul_a = w_uop.a_hi ? r_ma[mbe_pkg::Z_W-1:mbe_pkg::HALF_W]
                                : r_ma[mbe_pkg::HALF_W-1:0];
    assign w_mul_b = w_uop.b_hi ? r_mb[mbe_pkg::Z_W-1:mbe_pkg::HALF_W]
                                : r_mb[mbe_pkg::HALF_W-1:0];
    assign w_pp    = 64'(w_mul_a) * 64'(w_mul_b);

    always_comb begin
        unique case (w_uop.ash)
            mbe_pkg::ASH_0:  w_acc_add = {64'd0, r_pp};
            mbe_pkg::ASH_32: w_acc_add = {32'd0, r_pp, 32'd0};
            mbe_pkg::ASH_64: w_acc_add = {r_pp, 64'd0};
            default:         w_acc_add = '0;
        endcase
    end

    // Negating the exact product before dropping fraction bits gives the
    // floor of a negative result, as a plain arithmetic shift would.
    assign w_sgn  = r_neg ? (~r_acc + 128'd1) : r_acc;
    assign w_prod = w_sgn[FRAC_BITS+mbe_pkg::Z_W-1:FRAC_BITS];

    // Iteration update and escape test, both from the old z's products.
    assign w_zr_n = r_rr - r_ii + r_cr;
    assign w_zi_n = r_ri + r_ri + r_ci;
    assign w_mag  = r_rr + r_ii;
    assign w_esc  = $signed(w_mag) >= $signed(LimFive);

    assign w_at_limit  = (r_cnt >= r_limit);
    assign w_slot_free = !r_o_valid || o_res.ready;
    assign w_accept    = i_pt.valid && i_pt.ready;

    // ------------------------------------------------------------------
    // Sequencer and top-level control.
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_cnt     = r_cnt;
        n_res_esc = r_res_esc;
        unique case (r_state)
            S_IDLE: begin
                if (i_pt.valid) begin
                    n_state = S_RUN;
                    n_pc    = mbe_pkg::PC_CHECK;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                unique case (w_uop.br)
                    mbe_pkg::BR_LIMIT: begin
                        if (w_at_limit) begin
                            n_state   = S_DONE;
                            n_res_esc = 1'b0;
                        end else begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    mbe_pkg::BR_LOOP: begin
                        if (w_esc) begin
                            n_state   = S_DONE;
                            n_res_esc = 1'b1;
                        end else begin
                            n_pc  = mbe_pkg::PC_CHECK;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    mbe_pkg::BR_NEXT: n_pc = r_pc + 1'b1;
                    default:          n_pc = r_pc + 1'b1;
                endcase
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The output register stays loaded until the consumer takes it.
    always_comb begin
        n_o_valid = r_o_valid;
        if (r_state == S_DONE && w_slot_free) begin
            n_o_valid = 1'b1;
        end else if (o_res.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= mbe_pkg::PC_CHECK;
            r_cnt     <= '0;
            r_res_esc <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_cnt     <= n_cnt;
            r_res_esc <= n_res_esc;
            r_o_valid <= n_o_valid;
        end
    end

    // Datapath; payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_pt.valid) begin
            r_cr    <= i_pt.c_real;
            r_ci    <= i_pt.c_imag;
            r_zr    <= '0;
            r_zi    <= '0;
            r_limit <= COUNT_BITS'(r_max);
        end
        if (r_state == S_RUN) begin
            if (w_uop.ld) begin
                r_ma  <= w_opa[mbe_pkg::Z_W-1] ? (~w_opa + 64'd1) : w_opa;
                r_mb  <= w_opb[mbe_pkg::Z_W-1] ? (~w_opb + 64'd1) : w_opb;
                r_neg <= w_opa[mbe_pkg::Z_W-1] ^ w_opb[mbe_pkg::Z_W-1];
                r_acc <= '0;
            end
            if (w_uop.mul) begin
                r_pp <= w_pp;
            end
            if (w_uop.acc) begin
                r_acc <= r_acc + w_acc_add;
            end
            if (w_uop.st) begin
                unique case (w_uop.osel)
                    mbe_pkg::OP_RR: r_rr <= w_prod;
                    mbe_pkg::OP_II: r_ii <= w_prod;
                    mbe_pkg::OP_RI: r_ri <= w_prod;
                    default:        r_rr <= w_prod;
                endcase
            end
            if (w_uop.br == mbe_pkg::BR_LOOP) begin
                r_zr <= w_zr_n;
                r_zi <= w_zi_n;
            end
        end
        if (r_state == S_DONE && w_slot_free) begin
            r_o_cnt <= IcW'(r_cnt);
            r_o_esc <= r_res_esc;
        end
    end

    assign i_pt.ready            = (r_state == S_IDLE);
    assign o_res.valid           = r_o_valid;
    assign o_res.iteration_count = r_o_cnt;
    assign o_res.escaped         = r_o_esc;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_pc <= mbe_pkg::PC_UPD))
        else $error("step counter ran past the end of the program");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RUN) && (r_pc == mbe_pkg::PC_CHECK) && (r_cnt == '0))
        else $error("accepted request did not start the program at the limit check");

    a_esc_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_esc) |-> (r_cnt < r_limit))
        else $error("escape reported with count at or above the limit");

    a_limit_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_res_esc) |-> (r_cnt == r_limit))
        else $error("limit stop reported with count different from the limit");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench for mandelbrot_escape_iteration
// Drives points c over the request channel and compares every result with an
// in-bench escape-time predictor. The run walks through a number of
// iteration limits programmed over APB, from zero up to the full 16-bit range.
// Both channels idle at random, with calm stretches in between.
// ============================================================================

module tb;

    // The fraction width must match the parameter given to the block below.
    localparam int FRAC          = 56;
    localparam int RANDOM_POINTS = 1650;
    localparam int MAX_WAIT      = 17;
    localparam int TAIL_CYCLES   = 40;
    // Far above the slowest legal run, which stays under about 40 ms.
    localparam longint TIMEOUT_NS = 64'd200_000_000;

    // A register index with nothing behind it; writes to it must be ignored.
    localparam logic [mbe_pkg::APB_AW-3:0] CFG_SPARE = 1'b1;

    typedef logic signed [mbe_pkg::Z_W-1:0] t_coord;

    typedef struct packed {
        logic [mbe_pkg::IC_W-1:0] count;
        logic                     escaped;
    } t_escape_result;

    // How a random phase picks its iteration limit and its points.
    typedef enum logic [2:0] {
        PLAN_ZERO,
        PLAN_RESET,
        PLAN_FULL,
        PLAN_MID,
        PLAN_SHORT
    } t_limit_plan;

    localparam t_coord CMAX         = {1'b0, {(mbe_pkg::Z_W-1){1'b1}}};
    localparam t_coord CMIN         = {1'b1, {(mbe_pkg::Z_W-1){1'b0}}};
    // The loop stops once the integer part of |z|^2 is above 4, i.e. at 5.0.
    localparam t_coord ESCAPE_BOUND = t_coord'(64'd5 << FRAC);

    // Tracks the limit currently programmed and the results still owed by
    // the block, in request order.
    class t_escape_tracker;
        logic [mbe_pkg::MAXIT_W-1:0] limit;
        t_escape_result              pending_counts[$];
        int                          errors;
        int                          checked;
        int                          escaped_seen;

        function new();
            limit        = mbe_pkg::MAXIT_RST;
            errors       = 0;
            checked      = 0;
            escaped_seen = 0;
        endfunction

        // Exact 128-bit product, floored by the shift, low 64 bits kept.
        function t_coord fixed_mul(t_coord a, t_coord b);
            logic signed [2*mbe_pkg::Z_W-1:0] p;
            p = a * b;
            return p[FRAC +: mbe_pkg::Z_W];
        endfunction

        function t_escape_result escape_time(t_coord cr, t_coord ci);
            t_coord         zr, zi, rr, ii, ri, mag;
            t_escape_result r;
            zr = '0;
            zi = '0;
            r  = '0;
            while (r.count < limit && !r.escaped) begin
                rr  = fixed_mul(zr, zr);
                ii  = fixed_mul(zi, zi);
                ri  = fixed_mul(zr, zi);
                zr  = rr - ii + cr;
                zi  = ri + ri + ci;
                mag = rr + ii;
                if (mag >= ESCAPE_BOUND) begin
                    r.escaped = 1'b1;
                end else begin
                    r.count = r.count + 1'b1;
                end
            end
            return r;
        endfunction

        function void note_point(t_coord cr, t_coord ci);
            pending_counts.push_back(escape_time(cr, ci));
        endfunction

        function void check_result(logic [mbe_pkg::IC_W-1:0] count, logic escaped);
            t_escape_result want;
            if (pending_counts.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding: count %0d escaped %0b",
                         $time, count, escaped);
            end else begin
                want = pending_counts.pop_front();
                checked++;
                if (want.escaped) begin
                    escaped_seen++;
                end
                if (count !== want.count) begin
                    errors++;
                    $display("%0t: iteration_count expected %0d, got %0d",
                             $time, want.count, count);
                end
                if (escaped !== want.escaped) begin
                    errors++;
                    $display("%0t: escaped expected %0b, got %0b",
                             $time, want.escaped, escaped);
                end
            end
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [mbe_pkg::APB_AW-1:0] paddr;
    logic [mbe_pkg::APB_DW-1:0] pwdata;
    logic [mbe_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    mbe_in_if  pt ();
    mbe_out_if res ();

    t_escape_tracker tracker;
    // Remaining items of a calm stretch on each side; zero means idle at random.
    int send_calm = 0;
    int recv_calm = 0;
    int settings_used = 0;

    mandelbrot_escape_iteration #(
        .FRAC_BITS  (FRAC),
        .COUNT_BITS (mbe_pkg::IC_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Cycles to idle before the next item. Now and then a calm stretch of
    // back-to-back items starts, so the block also sees full-rate traffic.
    function automatic int draw_wait(inout int calm_left);
        int n;
        n = 0;
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(10, 40);
        end else begin
            n = $urandom_range(0, MAX_WAIT);
        end
        return n;
    endfunction

    // A fixed-point constant num / 2^halvings.
    function automatic t_coord fx_const(int num, int halvings);
        return t_coord'(64'(num) <<< (FRAC - halvings));
    endfunction

    // A value with an integer part in [lo, hi] and a random fraction.
    function automatic t_coord rand_coord(int lo, int hi);
        t_coord frac;
        int     whole;
        frac  = t_coord'({$urandom, $urandom}) & ((t_coord'(1) <<< FRAC) - 1);
        whole = lo + int'($urandom_range(0, hi - lo));
        return fx_const(whole, 0) | frac;
    endfunction

    // Under the full 16-bit limit only points that escape on the second pass are used,
    // since a point inside the set would iterate 65535 times. Elsewhere most
    // points sit around the set, some in the core, some are raw bit patterns.
    task automatic draw_point(input t_limit_plan plan, output t_coord cr, output t_coord ci);
        int pick;
        pick = $urandom_range(0, 99);
        if (plan == PLAN_FULL) begin
            cr = ($urandom_range(0, 1) != 0) ? rand_coord(3, 4) : rand_coord(-5, -4);
            ci = rand_coord(-2, 1);
        end else if (pick < 15) begin
            cr = t_coord'({$urandom, $urandom});
            ci = t_coord'({$urandom, $urandom});
        end else if (pick < 25) begin
            cr = rand_coord(-1, 0);
            ci = rand_coord(-1, 0);
        end else begin
            cr = rand_coord(-3, 1);
            ci = rand_coord(-2, 1);
        end
    endtask

    // Offers one point and returns at the edge where the request is taken.
    // With no gap drawn, valid simply stays high with the new payload.
    task automatic send_point(input t_coord cr, input t_coord ci);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            pt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt.valid  <= 1'b1;
        pt.c_real <= cr;
        pt.c_imag <= ci;
        do @(posedge i_clk); while (!pt.ready);
        tracker.note_point(cr, ci);
    endtask

    // Withdraws the request and holds off until every result is back.
    task automatic wait_drained();
        pt.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // An APB write, only ever issued with the block idle. The register takes
    // the value at the access edge; only the low 16 bits of the word count.
    task automatic program_register(input logic [mbe_pkg::APB_AW-3:0] index,
                                    input logic [mbe_pkg::APB_DW-1:0] data);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == mbe_pkg::CFG_MAX_ITER) begin
            tracker.limit = data[mbe_pkg::MAXIT_W-1:0];
            settings_used++;
        end
    endtask

    task automatic set_limit(input logic [mbe_pkg::MAXIT_W-1:0] lim);
        program_register(mbe_pkg::CFG_MAX_ITER, {16'($urandom), lim});
    endtask

    // Result side: accepts results with random stalls and checks each one.
    initial begin : result_sink
        int stall;
        res.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
            tracker.check_result(res.iteration_count, res.escaped);
        end
    end

    initial begin : stimulus
        int                          n;
        int                          made;
        int                          roll;
        t_limit_plan                 plan;
        logic [mbe_pkg::MAXIT_W-1:0] lim;
        t_coord                      cr;
        t_coord                      ci;

        tracker = new();
        i_rst_n   <= 1'b0;
        pt.valid  <= 1'b0;
        pt.c_real <= '0;
        pt.c_imag <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first group runs under the reset limit of 255 iterations.
        send_point('0, '0);                          // origin never escapes
        send_point(fx_const(5, 1), '0);              // 2.5 escapes on the second pass
        send_point(fx_const(2, 0), fx_const(1, 0));  // |c|^2 is exactly 5.0
        send_point(fx_const(2, 0), fx_const(1, 0) - 1); // one step below that
        send_point(fx_const(-2, 0), '0);             // |z|^2 stays at 4 for good
        send_point(fx_const(8, 0), fx_const(8, 0));  // rr + ii wraps negative
        send_point(fx_const(12, 0), '0);             // rr alone wraps
        send_point(CMAX, CMAX);
        send_point(CMIN, CMIN);
        send_point(CMIN, CMAX);
        send_point(t_coord'(-1), t_coord'(-1));      // one step below zero
        send_point(fx_const(-7, 2), '0);
        send_point(fx_const(1, 2), fx_const(1, 1));

        // A write to the unused index must leave the limit at 255.
        program_register(CFG_SPARE, $urandom);
        send_point(fx_const(1, 2), '0);

        // With a zero limit no pass runs at all.
        set_limit('0);
        send_point('0, '0);
        send_point(fx_const(5, 1), '0);
        send_point(CMAX, CMIN);

        // A limit of one stops 2.5 before its escape test; two lets it escape.
        set_limit(16'd1);
        send_point('0, '0);
        send_point(fx_const(5, 1), '0);
        set_limit(16'd2);
        send_point(fx_const(5, 1), '0);

        // Full 16-bit limit, with points that leave within a few passes.
        set_limit('1);
        send_point(fx_const(5, 1), '0);
        send_point('0, fx_const(-3, 0));
        send_point(fx_const(1, 0), '0);
        send_point(fx_const(-17, 3), '0);
        send_point(fx_const(-3, 0), fx_const(-3, 0));

        // Random phases, each under a freshly programmed limit. Most limits
        // are short so the run stays fast; the long ones get few points.
        made = 0;
        for (int ph = 0; made < RANDOM_POINTS; ph++) begin
            roll = $urandom_range(0, 9);
            unique case (roll)
                0:       plan = PLAN_ZERO;
                1:       plan = PLAN_RESET;
                2:       plan = PLAN_FULL;
                3:       plan = PLAN_MID;
                default: plan = PLAN_SHORT;
            endcase
            unique case (plan)
                PLAN_ZERO: begin
                    lim = '0;
                    n   = $urandom_range(10, 30);
                end
                PLAN_RESET: begin
                    lim = mbe_pkg::MAXIT_RST;
                    n   = $urandom_range(4, 8);
                end
                PLAN_FULL: begin
                    lim = '1;
                    n   = $urandom_range(10, 30);
                end
                PLAN_MID: begin
                    lim = mbe_pkg::MAXIT_W'($urandom_range(25, 64));
                    n   = $urandom_range(15, 30);
                end
                default: begin
                    lim = mbe_pkg::MAXIT_W'($urandom_range(1, 24));
                    n   = $urandom_range(60, 120);
                end
            endcase
            set_limit(lim);
            for (int i = 0; i < n; i++) begin
                // Halfway through the first phase, and some later ones, the
                // sender stops until the block has returned every result.
                if (i == n / 2 && (ph == 0 || $urandom_range(0, 3) == 0)) begin
                    wait_drained();
                end
                draw_point(plan, cr, ci);
                send_point(cr, ci);
                made++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d points checked under %0d programmed limits",
                 tracker.checked, settings_used);
        $display("tb: %0d escaped, %0d hit the limit",
                 tracker.escaped_seen, tracker.checked - tracker.escaped_seen);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: done, errors");
        $finish;
    end

endmodule
